// ===== rtl/assert_macros.svh =====
// assertion macros used by the sorted insert list rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SIL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SIL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SIL_ASSERT(lbl, clk, rst, prop, msg)
`define SIL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/sil_pkg.sv =====
// constants and types for the sorted insert list
package sil_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 2;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_IDX_W = 4;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 2'd0,
    OP_FIND_EQ   = 2'd1,
    OP_FIND_LESS = 2'd2
  } op_t;

  typedef struct packed {
    logic take;
    logic valid;
    logic eq;
  } sil_tap_t;

endpackage

// ===== rtl/sil_cell.sv =====
// one storage cell of the sorted list chain
module sil_cell
  import sil_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [VAL_W-1:0] key,
  input  logic                    ins,
  input  logic signed [VAL_W-1:0] prev_entry,
  input  sil_tap_t                prev_tap,
  output logic signed [VAL_W-1:0] entry,
  output sil_tap_t                tap
);

  logic valid;

  assign tap.valid = valid;
  assign tap.take  = !valid || (key > entry);
  assign tap.eq    = valid && (key == entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins) begin
      valid <= valid | prev_tap.valid;
    end
  end

  // shift down from the neighbour, or take the new word at the insert point
  always_ff @(posedge clk) begin
    if (ins) begin
      if (prev_tap.take) begin
        entry <= prev_entry;
      end else if (tap.take) begin
        entry <= key;
      end
    end
  end

endmodule

// ===== rtl/sorted_insert_list.sv =====
// sorted insert list: bounded descending list held in a chain of cells
// result: a word's result is registered and shown in the cycle after it is accepted
// throughput: one word per cycle; all cells compare against the key in the same cycle
// while the result register is waiting, a new word is taken only as the result leaves
// reset: synchronous, clears the entry count, every cell valid bit and the result flag
module sorted_insert_list
  import sil_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [OP_W-1:0]             op,
  input  logic signed [VAL_W-1:0]     value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [OUT_IDX_W-1:0]        index,
  output logic                        refused,
  output logic [OUT_CNT_W-1:0]        entry_count,
  output logic                        is_full
);

`include "assert_macros.svh"

  logic signed [VAL_W-1:0] cell_entry [CAPACITY];
  sil_tap_t                cell_tap   [CAPACITY];
  logic [CAPACITY-1:0]     take_vec;
  logic [CAPACITY-1:0]     valid_vec;
  logic [CAPACITY-1:0]     eq_vec;
  logic [CAPACITY-1:0]     take_start;
  logic [CAPACITY-1:0]     eq_start;
  logic [IDX_W-1:0]        take_idx;
  logic [IDX_W-1:0]        eq_idx;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    full;
  logic                    in_accept;
  logic                    ins;
  logic                    res_found;
  logic                    res_refused;
  logic [IDX_W-1:0]        res_idx;
  logic [IDX_W+OUT_IDX_W-1:0] idx_wide;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_wide;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign full      = (count == CNT_W'(CAPACITY));
  assign ins       = in_accept && (op_t'(op) == OP_INSERT) && !full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      sil_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .key        (value),
        .ins        (ins),
        .prev_entry ('0),
        .prev_tap   ('{take: 1'b0, valid: 1'b1, eq: 1'b0}),
        .entry      (cell_entry[i]),
        .tap        (cell_tap[i])
      );
    end else begin : g_body
      sil_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .key        (value),
        .ins        (ins),
        .prev_entry (cell_entry[i-1]),
        .prev_tap   (cell_tap[i-1]),
        .entry      (cell_entry[i]),
        .tap        (cell_tap[i])
      );
    end
    assign take_vec[i]  = cell_tap[i].take;
    assign valid_vec[i] = cell_tap[i].valid;
    assign eq_vec[i]    = cell_tap[i].eq;
  end

  // the take and match bits form single runs, so each start vector has at most one bit set
  assign take_start = take_vec & ~{take_vec[CAPACITY-2:0], 1'b0};
  assign eq_start   = eq_vec & ~{eq_vec[CAPACITY-2:0], 1'b0};

  always_comb begin
    take_idx = '0;
    eq_idx   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (take_start[i]) take_idx = take_idx | IDX_W'(i);
      if (eq_start[i])   eq_idx   = eq_idx | IDX_W'(i);
    end
  end

  always_comb begin
    res_found   = 1'b0;
    res_refused = 1'b0;
    res_idx     = '0;
    count_next  = count;
    unique case (op_t'(op))
      OP_INSERT: begin
        if (full) begin
          res_refused = 1'b1;
        end else begin
          res_found  = 1'b1;
          res_idx    = take_idx;
          count_next = count + 1'b1;
        end
      end
      OP_FIND_EQ: begin
        res_found = |eq_start;
        res_idx   = res_found ? eq_idx : '0;
      end
      OP_FIND_LESS: begin
        res_found = |(take_start & valid_vec);
        res_idx   = res_found ? take_idx : '0;
      end
      default: begin
      end
    endcase
  end

  assign idx_wide = {{OUT_IDX_W{1'b0}}, res_idx};
  assign cnt_wide = {{OUT_CNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      found       <= res_found;
      refused     <= res_refused;
      index       <= idx_wide[OUT_IDX_W-1:0];
      entry_count <= cnt_wide[OUT_CNT_W-1:0];
      is_full     <= (count_next == CNT_W'(CAPACITY));
    end
  end

  `SIL_ASSERT(a_take_start_onehot, clk, rst, $onehot0(take_start), "take start not one-hot")
  `SIL_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY), "entry count over capacity")
  `SIL_ASSERT(a_valid_matches_count, clk, rst, $countones(valid_vec) == int'(count), "valid bits off")
  `SIL_ASSERT(a_found_refused_excl, clk, rst, !(out_valid && found && refused), "found and refused")
  `SIL_ASSERT_NEXT(a_insert_grows, clk, rst, ins, count == $past(count) + 1'b1, "count did not grow")

endmodule

// ===== test/tb.sv =====
// testbench for the sorted insert list: scoreboard against a descending-list predictor
import sil_pkg::*;

typedef struct {
  logic                 found;
  logic [OUT_IDX_W-1:0] index;
  logic                 refused;
  logic [OUT_CNT_W-1:0] entry_count;
  logic                 is_full;
} list_result_t;

class list_scoreboard;
  logic signed [VAL_W-1:0] entries [CAPACITY];
  int unsigned             stored;
  list_result_t            pending [$];
  int                      errors;

  function new();
    stored = 0;
    errors = 0;
  endfunction

  function int unsigned first_smaller(logic signed [VAL_W-1:0] key);
    for (int i = 0; i < stored; i++) begin
      if (key > entries[i]) return i;
    end
    return stored;
  endfunction

  task report(string what);
    if (errors < 50) $display("error at %0t: %s", $realtime, what);
    errors++;
  endtask

  function void note_word(logic [OP_W-1:0] code, logic signed [VAL_W-1:0] key);
    list_result_t r;
    int unsigned  pos;
    r.found   = 1'b0;
    r.index   = '0;
    r.refused = 1'b0;
    case (code)
      OP_INSERT: begin
        if (stored >= CAPACITY) begin
          r.refused = 1'b1;
        end else begin
          pos = first_smaller(key);
          for (int k = stored; k > pos; k--) entries[k] = entries[k-1];
          entries[pos] = key;
          stored++;
          r.found = 1'b1;
          r.index = pos[OUT_IDX_W-1:0];
        end
      end
      OP_FIND_EQ: begin
        for (int i = 0; i < stored; i++) begin
          if (!r.found && key == entries[i]) begin
            r.found = 1'b1;
            r.index = i[OUT_IDX_W-1:0];
          end
        end
      end
      OP_FIND_LESS: begin
        pos = first_smaller(key);
        if (pos < stored) begin
          r.found = 1'b1;
          r.index = pos[OUT_IDX_W-1:0];
        end
      end
      default: ;
    endcase
    r.entry_count = stored[OUT_CNT_W-1:0];
    r.is_full     = (stored == CAPACITY);
    pending.push_back(r);
  endfunction

  task check_result(logic f, logic [OUT_IDX_W-1:0] idx, logic rf,
                    logic [OUT_CNT_W-1:0] cnt, logic full);
    list_result_t e;
    if (pending.size() == 0) begin
      report("result word with nothing expected");
      return;
    end
    e = pending.pop_front();
    if (f !== e.found) report($sformatf("found %b, expected %b", f, e.found));
    if (idx !== e.index) report($sformatf("index %0d, expected %0d", idx, e.index));
    if (rf !== e.refused) report($sformatf("refused %b, expected %b", rf, e.refused));
    if (cnt !== e.entry_count)
      report($sformatf("entry_count %0d, expected %0d", cnt, e.entry_count));
    if (full !== e.is_full) report($sformatf("is_full %b, expected %b", full, e.is_full));
  endtask
endclass

module tb;
  localparam logic [OP_W-1:0]         OP_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MAX   = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN   = 32'sh80000000;
  localparam int                      IDLE_LIMIT = 400;
  localparam int                      RANDOM_WORDS = 1900;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         op = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    found;
  logic [OUT_IDX_W-1:0]    index;
  logic                    refused;
  logic [OUT_CNT_W-1:0]    entry_count;
  logic                    is_full;

  list_scoreboard sb;
  bit             calm = 1'b0;
  int             idle_cycles = 0;

  sorted_insert_list u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .index       (index),
    .refused     (refused),
    .entry_count (entry_count),
    .is_full     (is_full)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // keys near stored entries so that equal and boundary cases come up often
  function automatic logic signed [VAL_W-1:0] pick_key();
    int r;
    logic signed [VAL_W-1:0] k;
    r = $urandom_range(0, 9);
    if (r < 5 && sb.stored > 0) begin
      k = sb.entries[$urandom_range(0, sb.stored - 1)];
      case ($urandom_range(0, 3))
        0: k = k + 1;
        1: k = k - 1;
        default: ;
      endcase
      return k;
    end
    if (r == 5) begin
      case ($urandom_range(0, 3))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_word(input logic [OP_W-1:0] code, input logic [VAL_W-1:0] key);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= code;
    value    <= key;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : stall_gen
    int run, hold;
    forever begin
      run = $urandom_range(1, 6);
      repeat (run) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      hold = pick_gap();
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_word(op, value);
      if (out_valid && !out_stall) sb.check_result(found, index, refused, entry_count, is_full);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int r;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list
    send_word(OP_FIND_EQ, '0);
    send_word(OP_FIND_LESS, VAL_MAX);
    send_word(OP_UNUSED, VAL_MAX);
    // extremes and a duplicate
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, VAL_MAX);
    send_word(OP_INSERT, VAL_MIN);
    send_word(OP_INSERT, '1);
    send_word(OP_INSERT, 32'sd1);
    send_word(OP_FIND_EQ, VAL_MIN);
    send_word(OP_FIND_EQ, VAL_MAX);
    send_word(OP_FIND_EQ, 32'sd5);
    send_word(OP_FIND_LESS, VAL_MIN);
    send_word(OP_FIND_LESS, VAL_MAX);
    send_word(OP_FIND_LESS, '0);
    // fill up, then a refused insert
    repeat (CAPACITY - 6) send_word(OP_INSERT, pick_key());
    send_word(OP_INSERT, '0);
    send_word(OP_UNUSED, '0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = ((n / 150) % 4 == 3);
      r = $urandom_range(0, 99);
      if (r < 10) send_word(OP_INSERT, pick_key());
      else if (r < 13) send_word(OP_UNUSED, $urandom);
      else if (r < 56) send_word(OP_FIND_EQ, pick_key());
      else send_word(OP_FIND_LESS, pick_key());
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== sorted_insert_list.f =====
+incdir+rtl
rtl/sil_pkg.sv
rtl/sil_cell.sv
rtl/sorted_insert_list.sv
test/tb.sv
